@@ rtl/core/hfe_pkg.sv @@
// hfe_pkg: types and constants shared by the header field extractor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hfe_pkg;

   localparam int MAX_NAME_LENGTH = 16;
   localparam int NAME_LEN_W      = 5;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 64;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_FIRST  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_SECOND = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_LENGTH = 2'd2;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   typedef enum logic [4:0] {
      PH_NAME  = 5'b00001,
      PH_SKIP  = 5'b00010,
      PH_VALUE = 5'b00100,
      PH_FOLD  = 5'b01000,
      PH_DONE  = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [7:0] header_byte;
      logic       end_of_header;
   } req_type;

   typedef struct packed {
      logic [7:0] value_byte;
      logic       byte_valid;
      logic       value_end;
      logic       field_found;
   } rsp_type;

   // all results caused by one item
   typedef struct packed {
      logic       has_space;
      logic       has_char;
      logic [7:0] char_byte;
      logic       has_end;
      logic       end_found;
   } bundle_type;

endpackage

`default_nettype wire

@@ rtl/core/hfe_front.sv @@
// hfe_front: name match and value parser, one byte per cycle while accept is high
// depends on hfe_pkg
`timescale 1ns / 1ps
`default_nettype none

module hfe_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [hfe_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [hfe_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                             accept,
   input  wire hfe_pkg::req_type                 item,
   output hfe_pkg::bundle_type                   bundle,
   output logic                                  bundle_valid
);

   logic [63:0]                      name_first_ff;
   logic [63:0]                      name_second_ff;
   logic [hfe_pkg::NAME_LEN_W-1:0]   name_length_ff;

   hfe_pkg::phase_type               phase_ff, phase_in, phase_mid;
   logic [hfe_pkg::NAME_LEN_W-1:0]   match_pos_ff, match_pos_in;
   logic                             blank_ff, blank_in;
   logic                             space_pend_ff, space_pend_in;
   logic                             started_ff, started_in;

   logic [hfe_pkg::NAME_LEN_W-1:0]   eff_len;
   logic [63:0]                      name_word;
   logic [7:0]                       name_byte;
   logic [7:0]                       c;
   logic                             is_sp_tab;
   logic                             is_ws;

   function automatic logic [7:0] lower_ascii(input logic [7:0] ch);
      logic [7:0] r;
      r = ch;
      if (ch >= 8'h41 && ch <= 8'h5A) begin
         r = ch + 8'd32;
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         name_first_ff  <= '0;
         name_second_ff <= '0;
         name_length_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            hfe_pkg::CSR_NAME_FIRST:  name_first_ff  <= csr_wdata;
            hfe_pkg::CSR_NAME_SECOND: name_second_ff <= csr_wdata;
            hfe_pkg::CSR_NAME_LENGTH:
               name_length_ff <= csr_wdata[hfe_pkg::NAME_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign eff_len = (name_length_ff > hfe_pkg::NAME_LEN_W'(hfe_pkg::MAX_NAME_LENGTH))
                    ? hfe_pkg::NAME_LEN_W'(hfe_pkg::MAX_NAME_LENGTH) : name_length_ff;
   assign name_word = match_pos_ff[3] ? name_second_ff : name_first_ff;
   assign name_byte = name_word[{match_pos_ff[2:0], 3'b000} +: 8];
   assign c         = item.header_byte;
   assign is_sp_tab = (c == hfe_pkg::CHAR_SPACE) || (c == hfe_pkg::CHAR_TAB);
   assign is_ws     = is_sp_tab || (c == hfe_pkg::CHAR_CR) || (c == hfe_pkg::CHAR_LF);

   always_comb begin
      phase_mid     = phase_ff;
      match_pos_in  = match_pos_ff;
      blank_in      = blank_ff;
      space_pend_in = space_pend_ff;
      started_in    = started_ff;
      bundle        = '0;

      case (phase_ff)
         hfe_pkg::PH_NAME, hfe_pkg::PH_SKIP: begin
            if (c == hfe_pkg::CHAR_LF) begin
               if (blank_ff) begin
                  bundle.has_end = 1'b1;
                  phase_mid      = hfe_pkg::PH_DONE;
               end else begin
                  phase_mid    = hfe_pkg::PH_NAME;
                  match_pos_in = '0;
                  blank_in     = 1'b1;
               end
            end else begin
               if (!is_ws) begin
                  blank_in = 1'b0;
               end
               if (phase_ff == hfe_pkg::PH_NAME) begin
                  if (match_pos_ff < eff_len) begin
                     if (lower_ascii(c) == lower_ascii(name_byte)) begin
                        match_pos_in = match_pos_ff + 1'b1;
                     end else begin
                        phase_mid = hfe_pkg::PH_SKIP;
                     end
                  end else if (c == hfe_pkg::CHAR_COLON) begin
                     phase_mid     = hfe_pkg::PH_VALUE;
                     space_pend_in = 1'b0;
                     started_in    = 1'b0;
                  end else if (!is_sp_tab) begin
                     phase_mid = hfe_pkg::PH_SKIP;
                  end
               end
            end
         end
         hfe_pkg::PH_FOLD: begin
            if (!is_sp_tab) begin
               bundle.has_end   = 1'b1;
               bundle.end_found = 1'b1;
               phase_mid        = hfe_pkg::PH_DONE;
            end else begin
               phase_mid     = hfe_pkg::PH_VALUE;
               space_pend_in = 1'b1;
            end
         end
         hfe_pkg::PH_VALUE: begin
            if (c == hfe_pkg::CHAR_LF) begin
               phase_mid     = hfe_pkg::PH_FOLD;
               space_pend_in = 1'b1;
            end else if (is_ws) begin
               space_pend_in = 1'b1;
            end else begin
               bundle.has_space = space_pend_ff && started_ff;
               bundle.has_char  = 1'b1;
               bundle.char_byte = c;
               started_in       = 1'b1;
               space_pend_in    = 1'b0;
            end
         end
         default: ;
      endcase

      phase_in = phase_mid;
      if (item.end_of_header) begin
         if (phase_mid inside {hfe_pkg::PH_NAME, hfe_pkg::PH_SKIP}) begin
            bundle.has_end   = 1'b1;
            bundle.end_found = 1'b0;
         end else if (phase_mid inside {hfe_pkg::PH_VALUE, hfe_pkg::PH_FOLD}) begin
            bundle.has_end   = 1'b1;
            bundle.end_found = 1'b1;
         end
         phase_in      = hfe_pkg::PH_NAME;
         match_pos_in  = '0;
         blank_in      = 1'b1;
         space_pend_in = 1'b0;
         started_in    = 1'b0;
      end
   end

   assign bundle_valid = accept && (bundle.has_space || bundle.has_char || bundle.has_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= hfe_pkg::PH_NAME;
         match_pos_ff  <= '0;
         blank_ff      <= 1'b1;
         space_pend_ff <= 1'b0;
         started_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         match_pos_ff  <= match_pos_in;
         blank_ff      <= blank_in;
         space_pend_ff <= space_pend_in;
         started_ff    <= started_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/hfe_queue.sv @@
// hfe_queue: short queue of result bundles between parser and serializer
// depends on hfe_pkg
`timescale 1ns / 1ps
`default_nettype none

module hfe_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 wr_en,
   input  wire hfe_pkg::bundle_type  wr_data,
   input  wire logic                 rd_en,
   output hfe_pkg::bundle_type       rd_data,
   output logic                      q_empty,
   output logic                      q_full
);

   hfe_pkg::bundle_type                slots_ff [hfe_pkg::QUEUE_DEPTH];
   logic [hfe_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [hfe_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [hfe_pkg::QUEUE_CNT_W-1:0]    count_ff, count_in;
   logic                               do_wr, do_rd;

   assign q_empty = (count_ff == '0);
   assign q_full  = (count_ff == hfe_pkg::QUEUE_CNT_W'(hfe_pkg::QUEUE_DEPTH));
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;
   assign rd_data = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slots_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/hfe_back.sv @@
// hfe_back: serializes each bundle into space, character and end items
// depends on hfe_pkg
`timescale 1ns / 1ps
`default_nettype none

module hfe_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire hfe_pkg::bundle_type  head,
   input  wire logic                 q_empty,
   output logic                      q_pop,
   output hfe_pkg::rsp_type          rsp_item,
   output logic                      empty,
   input  wire logic                 pop
);

   logic space_done_ff, space_done_in;
   logic char_done_ff, char_done_in;
   logic sel_space, sel_char, sel_end, last_piece, take;

   assign sel_space  = head.has_space && !space_done_ff;
   assign sel_char   = !sel_space && head.has_char && !char_done_ff;
   assign sel_end    = !sel_space && !sel_char;
   assign last_piece = sel_end || (sel_char && !head.has_end)
                       || (sel_space && !head.has_char && !head.has_end);

   assign empty = q_empty;
   assign take  = pop && !q_empty;
   assign q_pop = take && last_piece;

   always_comb begin
      rsp_item             = '0;
      rsp_item.byte_valid  = sel_space || sel_char;
      rsp_item.value_end   = sel_end;
      rsp_item.field_found = sel_end && head.end_found;
      if (sel_space) begin
         rsp_item.value_byte = hfe_pkg::CHAR_SPACE;
      end else if (sel_char) begin
         rsp_item.value_byte = head.char_byte;
      end
   end

   always_comb begin
      space_done_in = space_done_ff;
      char_done_in  = char_done_ff;
      if (take) begin
         if (last_piece) begin
            space_done_in = 1'b0;
            char_done_in  = 1'b0;
         end else begin
            space_done_in = space_done_ff || sel_space;
            char_done_in  = char_done_ff || sel_char;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         space_done_ff <= 1'b0;
         char_done_ff  <= 1'b0;
      end else begin
         space_done_ff <= space_done_in;
         char_done_ff  <= char_done_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/header_field_extractor.sv @@
// header_field_extractor: top level, parser front, bundle queue, serializer back
// depends on hfe_pkg, hfe_front, hfe_queue, hfe_back
// an accepted item's nonempty bundle is registered in the queue; rsp is decoded from its head
// throughput: one item per cycle unless full; an item yields up to three results, popped
// one per cycle by the serializer while pop is high, via a four-bundle queue from the parser
// reset: synchronous; clears parser state, queue and name registers
`timescale 1ns / 1ps
`default_nettype none

module header_field_extractor (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             push,
   output logic                                  full,
   input  wire hfe_pkg::req_type                 req_item,
   output logic                                  empty,
   input  wire logic                             pop,
   output hfe_pkg::rsp_type                      rsp_item,
   input  wire logic                             csr_we,
   input  wire logic [hfe_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [hfe_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   hfe_pkg::bundle_type bundle, head;
   logic                bundle_valid;
   logic                accept;
   logic                q_empty, q_full, q_pop;

   assign full   = q_full;
   assign accept = push && !q_full;

   hfe_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .accept       (accept),
      .item         (req_item),
      .bundle       (bundle),
      .bundle_valid (bundle_valid)
   );

   hfe_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (bundle_valid),
      .wr_data (bundle),
      .rd_en   (q_pop),
      .rd_data (head),
      .q_empty (q_empty),
      .q_full  (q_full)
   );

   hfe_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .rsp_item (rsp_item),
      .empty    (empty),
      .pop      (pop)
   );

   a_valid_not_end: assert property (@(posedge clock) disable iff (reset)
      !empty |-> !(rsp_item.byte_valid && rsp_item.value_end))
      else $error("result marked both value byte and end");

   a_found_on_end: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.field_found) |-> rsp_item.value_end)
      else $error("field_found set on a non-end result");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty)
      else $error("results pending after reset");

   a_end_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.value_end) |-> (rsp_item.value_byte == 8'h00))
      else $error("end result carries a byte");

endmodule

`default_nettype wire
